FILE: src/mbrf_pkg.sv
`default_nettype none
package mbrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int HDR_LEN   = 6;

    localparam logic [2:0] CMD_RD_COILS    = 3'd0;
    localparam logic [2:0] CMD_RD_DISCRETE = 3'd1;
    localparam logic [2:0] CMD_RD_HOLDING  = 3'd2;
    localparam logic [2:0] CMD_RD_INPUT    = 3'd3;
    localparam logic [2:0] CMD_WR_COIL     = 3'd4;
    localparam logic [2:0] CMD_WR_REG      = 3'd5;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] COIL_ON_VALUE = 16'hFF00;

    localparam logic [17:0] REPLY_COIL_BASE = 18'd6;
    localparam logic [17:0] REPLY_REG_BASE  = 18'd5;
    localparam logic [17:0] REPLY_WRITE     = 18'd8;

    localparam logic [2:0] POS_CRC_LO = 3'd6;
    localparam logic [2:0] POS_CRC_HI = 3'd7;

    typedef struct packed {
        logic [HDR_LEN-1:0][7:0] hdr;
        logic [15:0]             crc;
        logic [17:0]             reply;
        logic                    rejected;
    } frame_t;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/mbrf_if.sv
`default_nettype none
interface mbrf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  slave_id;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic        coil_on;

    modport source (output valid, cmd, slave_id, start_address, quantity_or_value, coil_on,
                    input ready);
    modport sink (input valid, cmd, slave_id, start_address, quantity_or_value, coil_on,
                  output ready);
endinterface

interface mbrf_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        rejected;
    logic [17:0] expected_reply_length;

    modport source (output valid, frame_byte, last_byte, rejected, expected_reply_length,
                    input ready);
    modport sink (input valid, frame_byte, last_byte, rejected, expected_reply_length,
                  output ready);
endinterface
`default_nettype wire

FILE: src/mbrf_decode.sv
`default_nettype none
module mbrf_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mbrf_req_if.sink            req,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mbrf_pkg::frame_t    out_frame
);

    logic              valid_reg;
    mbrf_pkg::frame_t  frame_reg;
    mbrf_pkg::frame_t  frame_next;
    logic [15:0]       data;

    assign req.ready = !valid_reg || out_ready;

    always_comb
    begin
        data = req.quantity_or_value;
        frame_next.reply = '0;
        frame_next.rejected = 1'b0;
        case (req.cmd)
            mbrf_pkg::CMD_RD_COILS, mbrf_pkg::CMD_RD_DISCRETE:
            begin
                frame_next.reply = mbrf_pkg::REPLY_COIL_BASE
                                   + {5'd0, req.quantity_or_value[15:3]};
            end
            mbrf_pkg::CMD_RD_HOLDING, mbrf_pkg::CMD_RD_INPUT:
            begin
                frame_next.reply = mbrf_pkg::REPLY_REG_BASE
                                   + {1'b0, req.quantity_or_value, 1'b0};
            end
            mbrf_pkg::CMD_WR_COIL:
            begin
                data = req.coil_on ? mbrf_pkg::COIL_ON_VALUE : 16'h0000;
                frame_next.reply = mbrf_pkg::REPLY_WRITE;
            end
            mbrf_pkg::CMD_WR_REG:
            begin
                frame_next.reply = mbrf_pkg::REPLY_WRITE;
            end
            default:
            begin
                frame_next.rejected = 1'b1;
            end
        endcase
        frame_next.hdr[0] = req.slave_id;
        frame_next.hdr[1] = {5'd0, req.cmd} + 8'd1;
        frame_next.hdr[2] = req.start_address[15:8];
        frame_next.hdr[3] = req.start_address[7:0];
        frame_next.hdr[4] = data[15:8];
        frame_next.hdr[5] = data[7:0];
        frame_next.crc    = mbrf_pkg::CRC_INIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            frame_reg <= frame_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

endmodule
`default_nettype wire

FILE: src/mbrf_crc_stage.sv
`default_nettype none
module mbrf_crc_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mbrf_pkg::frame_t  in_frame,
    input  wire logic [7:0]        in_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mbrf_pkg::frame_t       out_frame
);

    logic              valid_reg;
    mbrf_pkg::frame_t  frame_reg;
    mbrf_pkg::frame_t  frame_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        frame_next     = in_frame;
        frame_next.crc = mbrf_pkg::crc_byte(in_frame.crc, in_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            frame_reg <= frame_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

endmodule
`default_nettype wire

FILE: src/mbrf_serializer.sv
`default_nettype none
module mbrf_serializer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mbrf_pkg::frame_t  in_frame,
    mbrf_byte_if.source            rsp
);

    logic              valid_reg;
    logic [2:0]        cnt_reg;
    logic [2:0]        cnt_next;
    mbrf_pkg::frame_t  frame_reg;
    logic              last;
    logic              take;

    assign last     = frame_reg.rejected || (cnt_reg == mbrf_pkg::POS_CRC_HI);
    assign take     = rsp.valid && rsp.ready;
    // next frame loads as the final byte of the current one leaves
    assign in_ready = !valid_reg || (take && last);
    assign cnt_next = in_ready ? 3'd0 : (take ? cnt_reg + 3'd1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            frame_reg <= in_frame;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            3'd0:                 rsp.frame_byte = frame_reg.hdr[0];
            3'd1:                 rsp.frame_byte = frame_reg.hdr[1];
            3'd2:                 rsp.frame_byte = frame_reg.hdr[2];
            3'd3:                 rsp.frame_byte = frame_reg.hdr[3];
            3'd4:                 rsp.frame_byte = frame_reg.hdr[4];
            3'd5:                 rsp.frame_byte = frame_reg.hdr[5];
            mbrf_pkg::POS_CRC_LO: rsp.frame_byte = frame_reg.crc[7:0];
            default:              rsp.frame_byte = frame_reg.crc[15:8];
        endcase
        if (frame_reg.rejected)
        begin
            rsp.frame_byte = 8'h00;
        end
    end

    assign rsp.valid                 = valid_reg;
    assign rsp.last_byte             = last;
    assign rsp.rejected              = frame_reg.rejected;
    assign rsp.expected_reply_length = frame_reg.reply;

endmodule
`default_nettype wire

FILE: src/modbus_rtu_request_framer_unit.sv
// the first frame byte is valid once the request has passed the decode, crc and serializer registers
// throughput: one byte per cycle while rsp.ready is high; a full request is eight bytes, rejected ones go one per cycle
// the crc is built one byte per stage over six stages after a decode stage
// asynchronous active-low reset clears only the valid bits and the byte counter
`default_nettype none
module modbus_rtu_request_framer_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mbrf_req_if.sink      req,
    mbrf_byte_if.source   rsp
);

    localparam int NSTG = mbrf_pkg::HDR_LEN;

    mbrf_pkg::frame_t  stg_frame [0:NSTG];
    logic              stg_valid [0:NSTG];
    logic              stg_ready [0:NSTG];

    mbrf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_frame (stg_frame[0])
    );

    for (genvar i = 0; i < NSTG; i++)
    begin : g_crc
        mbrf_crc_stage u_crc (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_frame  (stg_frame[i]),
            .in_byte   (stg_frame[i].hdr[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_frame (stg_frame[i+1])
        );
    end

    mbrf_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[NSTG]),
        .in_ready (stg_ready[NSTG]),
        .in_frame (stg_frame[NSTG]),
        .rsp      (rsp)
    );

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.rejected |->
            rsp.frame_byte == 8'h00 && rsp.expected_reply_length == 18'd0 && rsp.last_byte)
        else $error("rejected request carries frame data");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && !rsp.last_byte |=> rsp.valid && !rsp.rejected)
        else $error("frame broken before its last byte");

    a_reply_steady: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && !rsp.last_byte |=> $stable(rsp.expected_reply_length))
        else $error("reply length changed inside a frame");

endmodule
`default_nettype wire

FILE: verif/modbus_rtu_request_framer_unit_test.sv
typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  slave_id;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic        coil_on;
} mb_request_t;

typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        rejected;
    logic [17:0] reply_len;
} mb_frame_byte_t;

class frame_scoreboard;
    mb_frame_byte_t expected_bytes[$];
    int errors;
    int frames_built;
    int rejects_built;
    int bytes_checked;

    function new();
        errors = 0;
        frames_built = 0;
        rejects_built = 0;
        bytes_checked = 0;
    endfunction

    function logic [15:0] modbus_crc(logic [7:0] hdr [6]);
        logic [15:0] crc;
        crc = mbrf_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++)
        begin
            crc = crc ^ {8'h00, hdr[i]};
            for (int b = 0; b < 8; b++)
            begin
                if (crc[0])
                    crc = (crc >> 1) ^ mbrf_pkg::CRC_POLY;
                else
                    crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    // works out the frame bytes an accepted request must produce
    function void note_request(mb_request_t r);
        logic [7:0]     hdr [6];
        logic [15:0]    data;
        logic [17:0]    reply;
        logic [15:0]    crc;
        mb_frame_byte_t fb;
        logic           valid_cmd;
        valid_cmd = 1'b1;
        data = r.quantity_or_value;
        reply = '0;
        case (r.cmd)
            mbrf_pkg::CMD_RD_COILS, mbrf_pkg::CMD_RD_DISCRETE:
                reply = mbrf_pkg::REPLY_COIL_BASE + ({2'b00, r.quantity_or_value} >> 3);
            mbrf_pkg::CMD_RD_HOLDING, mbrf_pkg::CMD_RD_INPUT:
                reply = mbrf_pkg::REPLY_REG_BASE + 18'd2 * {2'b00, r.quantity_or_value};
            mbrf_pkg::CMD_WR_COIL:
            begin
                data = r.coil_on ? mbrf_pkg::COIL_ON_VALUE : 16'h0000;
                reply = mbrf_pkg::REPLY_WRITE;
            end
            mbrf_pkg::CMD_WR_REG:
                reply = mbrf_pkg::REPLY_WRITE;
            default:
                valid_cmd = 1'b0;
        endcase
        if (!valid_cmd)
        begin
            fb.frame_byte = 8'h00;
            fb.last_byte = 1'b1;
            fb.rejected = 1'b1;
            fb.reply_len = '0;
            expected_bytes.push_back(fb);
            rejects_built++;
            return;
        end
        hdr[0] = r.slave_id;
        hdr[1] = {5'd0, r.cmd} + 8'd1;
        hdr[2] = r.start_address[15:8];
        hdr[3] = r.start_address[7:0];
        hdr[4] = data[15:8];
        hdr[5] = data[7:0];
        crc = modbus_crc(hdr);
        for (int k = 0; k < mbrf_pkg::FRAME_LEN; k++)
        begin
            if (k < 6)
                fb.frame_byte = hdr[k];
            else if (k == 6)
                fb.frame_byte = crc[7:0];
            else
                fb.frame_byte = crc[15:8];
            fb.last_byte = (k == mbrf_pkg::FRAME_LEN - 1);
            fb.rejected = 1'b0;
            fb.reply_len = reply;
            expected_bytes.push_back(fb);
        end
        frames_built++;
    endfunction

    function void check_byte(mb_frame_byte_t got);
        mb_frame_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            $display("%0t: unexpected frame byte: expected none, got %h/%b/%b/%0d", $time,
                     got.frame_byte, got.last_byte, got.rejected, got.reply_len);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.frame_byte !== want.frame_byte)
        begin
            $display("%0t: frame_byte: expected %h, got %h", $time,
                     want.frame_byte, got.frame_byte);
            errors++;
        end
        if (got.last_byte !== want.last_byte)
        begin
            $display("%0t: last_byte: expected %b, got %b", $time,
                     want.last_byte, got.last_byte);
            errors++;
        end
        if (got.rejected !== want.rejected)
        begin
            $display("%0t: rejected: expected %b, got %b", $time,
                     want.rejected, got.rejected);
            errors++;
        end
        if (got.reply_len !== want.reply_len)
        begin
            $display("%0t: expected_reply_length: expected %0d, got %0d", $time,
                     want.reply_len, got.reply_len);
            errors++;
        end
        bytes_checked++;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module modbus_rtu_request_framer_unit_test;

    localparam logic [2:0] CMD_BAD_6 = 3'd6;
    localparam logic [2:0] CMD_BAD_7 = 3'd7;
    localparam int RANDOM_REQUESTS = 250;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;

    logic clk;
    logic rst_n;

    mbrf_req_if  req_ch ();
    mbrf_byte_if rsp_ch ();

    frame_scoreboard sb;
    int requests_sent;
    int idle_cycles;

    modbus_rtu_request_framer_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly random ranges, with a good share of extremes
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_request(input mb_request_t r);
        int gap;
        // every third stretch of 30 requests runs without gaps
        gap = ((requests_sent / 30) % 3 == 1) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.cmd               <= r.cmd;
        req_ch.slave_id          <= r.slave_id;
        req_ch.start_address     <= r.start_address;
        req_ch.quantity_or_value <= r.quantity_or_value;
        req_ch.coil_on           <= r.coil_on;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic send_fields(input logic [2:0] cmd, input logic [7:0] slave_id,
                               input logic [15:0] addr, input logic [15:0] qv,
                               input logic coil_on);
        mb_request_t r;
        r.cmd = cmd;
        r.slave_id = slave_id;
        r.start_address = addr;
        r.quantity_or_value = qv;
        r.coil_on = coil_on;
        send_request(r);
    endtask

    // response side: random stalls, with calm stretches
    initial
    begin
        int stall;
        int taken;
        mb_frame_byte_t got;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ((taken / 40) % 3 == 2) ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got.frame_byte = rsp_ch.frame_byte;
            got.last_byte = rsp_ch.last_byte;
            got.rejected = rsp_ch.rejected;
            got.reply_len = rsp_ch.expected_reply_length;
            sb.check_byte(got);
            taken++;
        end
    end

    // watchdog on cycles where neither side moves anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d bytes still expected",
                         $time, idle_cycles, sb.pending());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        mb_request_t r;
        sb = new();
        requests_sent = 0;
        idle_cycles = 0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd <= mbrf_pkg::CMD_RD_COILS;
        req_ch.slave_id <= '0;
        req_ch.start_address <= '0;
        req_ch.quantity_or_value <= '0;
        req_ch.coil_on <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each command, rounding and rejects
        send_fields(mbrf_pkg::CMD_RD_COILS,    8'h00, 16'h0000, 16'h0000, 1'b0);
        send_fields(mbrf_pkg::CMD_RD_COILS,    8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_fields(mbrf_pkg::CMD_RD_DISCRETE, 8'h01, 16'h0013, 16'h0007, 1'b0);
        send_fields(mbrf_pkg::CMD_RD_DISCRETE, 8'h01, 16'h0013, 16'h0008, 1'b1);
        send_fields(mbrf_pkg::CMD_RD_HOLDING,  8'h11, 16'h006B, 16'hFFFF, 1'b0);
        send_fields(mbrf_pkg::CMD_RD_HOLDING,  8'hFF, 16'h0000, 16'h0000, 1'b0);
        send_fields(mbrf_pkg::CMD_RD_INPUT,    8'h11, 16'hFFFF, 16'h0001, 1'b1);
        send_fields(mbrf_pkg::CMD_RD_INPUT,    8'h80, 16'h8000, 16'h8000, 1'b0);
        // coil value comes from coil_on alone
        send_fields(mbrf_pkg::CMD_WR_COIL,     8'h11, 16'h00AC, 16'h1234, 1'b1);
        send_fields(mbrf_pkg::CMD_WR_COIL,     8'h00, 16'hFFFF, 16'hFFFF, 1'b0);
        send_fields(mbrf_pkg::CMD_WR_COIL,     8'hFF, 16'h0000, 16'h0000, 1'b1);
        send_fields(mbrf_pkg::CMD_WR_REG,      8'h11, 16'h0001, 16'hFFFF, 1'b1);
        send_fields(mbrf_pkg::CMD_WR_REG,      8'h00, 16'h0000, 16'h0000, 1'b0);
        // rejects back to back and between frames
        send_fields(CMD_BAD_6,                 8'h00, 16'h0000, 16'h0000, 1'b0);
        send_fields(CMD_BAD_7,                 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_fields(CMD_BAD_6,                 8'h5A, 16'hA5A5, 16'h1234, 1'b1);
        send_fields(mbrf_pkg::CMD_RD_COILS,    8'h01, 16'h0001, 16'h0001, 1'b0);
        send_fields(CMD_BAD_7,                 8'h01, 16'h0002, 16'h0003, 1'b0);
        send_fields(mbrf_pkg::CMD_WR_REG,      8'hF7, 16'h7FFF, 16'h8001, 1'b0);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            r.cmd = 3'($urandom_range(0, 7));
            r.slave_id = 8'($urandom_range(0, 255));
            r.start_address = pick_word();
            r.quantity_or_value = pick_word();
            r.coil_on = 1'($urandom_range(0, 1));
            send_request(r);
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d frames and %0d rejections predicted",
                 requests_sent, sb.frames_built, sb.rejects_built);
        $display("summary: %0d output bytes compared, %0d mismatches",
                 sb.bytes_checked, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
